[rtl/qamhd_pkg.sv]
// qamhd_pkg: shared widths, constellation constants and slicing tables
// for the qam hard decision demapper; no dependencies
`default_nettype none

package qamhd_pkg;

   localparam int SAMPLE_WIDTH     = 16;
   localparam int FRAC_BITS        = 13;
   localparam int ORDER_WIDTH      = 2;
   localparam int NUM_ORDERS       = 4;
   localparam int MAX_THR          = 7;
   localparam int NUM_MAGS         = MAX_THR + 1;
   localparam int COUNT_WIDTH      = 3;
   localparam int LOWER_BITS       = 3;
   localparam int AXIS_BITS        = LOWER_BITS + 1;
   localparam int LABEL_WIDTH      = 8;
   localparam int LABEL_BITS_WIDTH = 4;
   localparam int THR_WIDTH        = SAMPLE_WIDTH + 2;

   localparam logic [ORDER_WIDTH-1:0] ORDER_QPSK   = 2'd0;
   localparam logic [ORDER_WIDTH-1:0] ORDER_QAM16  = 2'd1;
   localparam logic [ORDER_WIDTH-1:0] ORDER_QAM64  = 2'd2;
   localparam logic [ORDER_WIDTH-1:0] ORDER_QAM256 = 2'd3;

   localparam longint NORM_QPSK   = 2;
   localparam longint NORM_QAM16  = 10;
   localparam longint NORM_QAM64  = 42;
   localparam longint NORM_QAM256 = 170;

   // above any value that twice the sample magnitude can take
   localparam longint THR_CLAMP = longint'(1) << (SAMPLE_WIDTH + 1);

   typedef logic [NUM_ORDERS-1:0][MAX_THR-1:0][THR_WIDTH-1:0] thr_table_type;
   typedef logic [NUM_ORDERS-1:0][NUM_MAGS-1:0][LOWER_BITS-1:0] pat_table_type;

   function automatic longint norm_of(int ord);
      longint n;
      unique case (ord)
         0: n = NORM_QPSK;
         1: n = NORM_QAM16;
         2: n = NORM_QAM64;
         default: n = NORM_QAM256;
      endcase
      return n;
   endfunction

   // round(mag * 2^FRAC_BITS / sqrt(norm)), exact integer search
   function automatic longint round_level(longint mag, longint norm);
      logic [63:0] rhs;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] u;
      rhs = (64'(4) * 64'(mag) * 64'(mag)) << (2 * FRAC_BITS);
      lo  = 64'd0;
      hi  = 64'(mag) << FRAC_BITS;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 64'd1) >> 1);
         u   = (mid << 1) - 64'd1;
         if (64'(norm) * u * u <= rhs) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      return longint'(lo);
   endfunction

   // odd magnitude index selected by the non-sign bits of a k-bit axis pattern
   function automatic int level_mag_of(int pat, int k);
      int t;
      int s;
      int j;
      t = 1;
      if (k > 1) begin
         s = ((pat & 1) != 0) ? -1 : 1;
         t = 2 - s;
         for (j = k - 2; j >= 1; j--) begin
            s = (((pat >> (k - 1 - j)) & 1) != 0) ? -1 : 1;
            t = (1 << (k - j)) - s * t;
         end
      end
      return t;
   endfunction

   // non-sign axis bits for the c-th smallest magnitude
   function automatic int lower_of(int ord, int c);
      int res;
      int p;
      res = 0;
      for (p = 0; p < (1 << ord); p++) begin
         if (level_mag_of(p, ord + 1) == 2 * c + 1) begin
            res = p;
         end
      end
      return res;
   endfunction

   // midpoint sums between adjacent magnitudes, nudged by one where the
   // lower magnitude wins the tie
   function automatic thr_table_type build_thr_table();
      thr_table_type tab;
      longint s;
      int o;
      int j;
      for (o = 0; o < NUM_ORDERS; o++) begin
         for (j = 0; j < MAX_THR; j++) begin
            if (j < (1 << o) - 1) begin
               s = round_level(longint'(2 * j + 1), norm_of(o))
                 + round_level(longint'(2 * j + 3), norm_of(o));
               if (lower_of(o, j + 1) <= lower_of(o, j)) begin
                  s = s + 1;
               end
               if (s > THR_CLAMP) begin
                  s = THR_CLAMP;
               end
            end else begin
               s = THR_CLAMP;
            end
            tab[o][j] = THR_WIDTH'(s);
         end
      end
      return tab;
   endfunction

   function automatic pat_table_type build_pat_table();
      pat_table_type tab;
      int o;
      int c;
      for (o = 0; o < NUM_ORDERS; o++) begin
         for (c = 0; c < NUM_MAGS; c++) begin
            if (c < (1 << o)) begin
               tab[o][c] = LOWER_BITS'(lower_of(o, c));
            end else begin
               tab[o][c] = '0;
            end
         end
      end
      return tab;
   endfunction

   localparam thr_table_type THR_TABLE = build_thr_table();
   localparam pat_table_type PAT_TABLE = build_pat_table();

endpackage

`default_nettype wire

[rtl/qam_hard_decision_demapper.sv]
// qam_hard_decision_demapper: top level, per-axis threshold slicer
// depends on qamhd_pkg for widths and the threshold and pattern tables
`default_nettype none

// hard decision demapper for qpsk, 16qam, 64qam and 256qam (38.211 mapping)
//
// request channel: start with req_i_sample / req_q_sample (signed q2.13);
//   a request is taken at a rising edge with start high and busy low
// busy is high only while reset is asserted, so one request per clock
//   is taken in normal operation
// result channel: rsp_valid marks rsp_bit_label and rsp_label_bits for
//   exactly one cycle; there is no back-pressure
// pipeline: a taken request passes through the input register, the
//   combinational slicer and the result register before its result
//   appears on the ports
// throughput: one request per clock, set by the combinational slicer
// slicing: each axis gives its sign bit from the sample sign and its
//   remaining bits from up to seven magnitude comparators against
//   constant midpoints; ties go to the larger label
// csr: csr_we writes csr_wdata into the modulation order (reset qpsk);
//   it is to be written only when no request is in flight
// reset: synchronous, clears the order and all valid flags

module qam_hard_decision_demapper (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic signed [qamhd_pkg::SAMPLE_WIDTH-1:0] req_i_sample,
   input  wire logic signed [qamhd_pkg::SAMPLE_WIDTH-1:0] req_q_sample,
   output logic                                         rsp_valid,
   output logic [qamhd_pkg::LABEL_WIDTH-1:0]            rsp_bit_label,
   output logic [qamhd_pkg::LABEL_BITS_WIDTH-1:0]       rsp_label_bits,
   input  wire logic                                    csr_we,
   input  wire logic [qamhd_pkg::ORDER_WIDTH-1:0]       csr_wdata
);

   // slice one axis: sign from the sample, magnitude bits from thresholds
   function automatic logic [qamhd_pkg::AXIS_BITS-1:0] slice_axis(
      logic signed [qamhd_pkg::SAMPLE_WIDTH-1:0] x,
      logic [qamhd_pkg::ORDER_WIDTH-1:0]         ord
   );
      logic                                 neg;
      logic [qamhd_pkg::SAMPLE_WIDTH-1:0]   mag;
      logic [qamhd_pkg::THR_WIDTH-1:0]      twice;
      logic [qamhd_pkg::COUNT_WIDTH-1:0]    count;
      logic [qamhd_pkg::LOWER_BITS-1:0]     lower;
      logic [qamhd_pkg::AXIS_BITS-1:0]      pat;
      // zero sits on the midpoint of the two inner levels: negative wins
      neg   = x[qamhd_pkg::SAMPLE_WIDTH-1] || (x == '0);
      mag   = x[qamhd_pkg::SAMPLE_WIDTH-1] ? (~x + 1'b1) : x;
      twice = {1'b0, mag, 1'b0};
      count = '0;
      for (int j = 0; j < qamhd_pkg::MAX_THR; j++) begin
         count = count + qamhd_pkg::COUNT_WIDTH'(twice >= qamhd_pkg::THR_TABLE[ord][j]);
      end
      lower = qamhd_pkg::PAT_TABLE[ord][count];
      pat   = (qamhd_pkg::AXIS_BITS'(neg) << ord)
            | qamhd_pkg::AXIS_BITS'(lower);
      return pat;
   endfunction

   // configuration
   logic [qamhd_pkg::ORDER_WIDTH-1:0] order_ff;
   logic [qamhd_pkg::ORDER_WIDTH-1:0] order_in;

   // input register
   logic                                        valid_s1_ff;
   logic                                        valid_s1_in;
   logic signed [qamhd_pkg::SAMPLE_WIDTH-1:0]   sample_i_ff;
   logic signed [qamhd_pkg::SAMPLE_WIDTH-1:0]   sample_i_in;
   logic signed [qamhd_pkg::SAMPLE_WIDTH-1:0]   sample_q_ff;
   logic signed [qamhd_pkg::SAMPLE_WIDTH-1:0]   sample_q_in;

   // result register
   logic                                        rsp_valid_ff;
   logic                                        rsp_valid_in;
   logic [qamhd_pkg::LABEL_WIDTH-1:0]           label_ff;
   logic [qamhd_pkg::LABEL_WIDTH-1:0]           label_in;
   logic [qamhd_pkg::LABEL_BITS_WIDTH-1:0]      nbits_ff;
   logic [qamhd_pkg::LABEL_BITS_WIDTH-1:0]      nbits_in;

   logic                                        req_accept;
   logic [qamhd_pkg::AXIS_BITS-1:0]             pat_i;
   logic [qamhd_pkg::AXIS_BITS-1:0]             pat_q;

   // only held off while in reset
   assign busy       = reset;
   assign req_accept = start && !busy;

   assign order_in    = csr_we ? csr_wdata : order_ff;
   assign valid_s1_in = req_accept;
   assign sample_i_in = req_accept ? req_i_sample : sample_i_ff;
   assign sample_q_in = req_accept ? req_q_sample : sample_q_ff;

   always_comb begin
      pat_i = slice_axis(sample_i_ff, order_ff);
      pat_q = slice_axis(sample_q_ff, order_ff);
      // i bits on the odd label positions, q bits on the even ones;
      // pattern bits above the order are already zero
      label_in = '0;
      for (int b = 0; b < qamhd_pkg::AXIS_BITS; b++) begin
         label_in[2 * b + 1] = pat_i[b];
         label_in[2 * b]     = pat_q[b];
      end
      nbits_in     = qamhd_pkg::LABEL_BITS_WIDTH'({order_ff, 1'b0}) + 4'd2;
      rsp_valid_in = valid_s1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff     <= qamhd_pkg::ORDER_QPSK;
         valid_s1_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         order_ff     <= order_in;
         valid_s1_ff  <= valid_s1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      sample_i_ff <= sample_i_in;
      sample_q_ff <= sample_q_in;
      if (valid_s1_ff) begin
         label_ff <= label_in;
         nbits_ff <= nbits_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bit_label  = label_ff;
   assign rsp_label_bits = nbits_ff;

   // a taken request reaches the slicer stage on the next edge
   a_accept_to_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> valid_s1_ff)
      else $error("accepted request did not reach slicer stage");

   // every sliced sample yields a result in the following cycle
   a_s1_to_rsp: assert property (@(posedge clock) disable iff (reset)
      valid_s1_ff |=> rsp_valid_ff)
      else $error("sliced sample produced no result");

   // label width follows the selected order
   a_nbits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_label_bits
                        == (qamhd_pkg::LABEL_BITS_WIDTH'({order_ff, 1'b0}) + 4'd2)))
      else $error("label width does not match modulation order");

   // label bits above the valid count stay clear
   a_label_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_bit_label >> rsp_label_bits) == '0))
      else $error("label has bits above its width");

endmodule

`default_nettype wire
